@@ src/sor_pkg.sv @@
// Shared types and constants for the SOR linear solver.
// No dependencies; used by sor_div and sor_linear_solver.
package sor_pkg;

    localparam int DIV_W  = 50;
    localparam int DIV_CW = 6;

    localparam logic [17:0] W_ONE = 18'd65536;
    localparam logic [17:0] W_MAX = 18'd131072;

    localparam logic [1:0] REG_RELAX = 2'd0;
    localparam logic [1:0] REG_TOL   = 2'd1;
    localparam logic [1:0] REG_ITER  = 2'd2;
    localparam logic [1:0] REG_SIZE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_RES,
        ST_M1,
        ST_M2,
        ST_DIV,
        ST_WAIT,
        ST_UPD,
        ST_SWEEP,
        ST_ORD,
        ST_OWR
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        logic signed [31:0] r;
        if (v > 53'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -53'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/sor_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sor_pkg.
module sor_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [sor_pkg::DIV_W-1:0]    dividend,
    input  logic signed [31:0]                  divisor,
    output logic                                done,
    output logic signed [sor_pkg::DIV_W-1:0]    quotient
);
    localparam int DW = sor_pkg::DIV_W;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [sor_pkg::DIV_CW-1:0] cnt_reg;
    logic [32:0]                rem_reg, dsr_reg;
    logic [DW-1:0]              q_reg;
    logic                       neg_reg;
    logic [32:0]                rem_sh;
    logic                       ge;

    assign rem_sh = {rem_reg[31:0], q_reg[DW-1]};
    assign ge     = rem_sh >= dsr_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == sor_pkg::DIV_CW'(DW - 1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            dsr_reg <= divisor[31] ? 33'(-{divisor[31], divisor}) : {1'b0, divisor};
            rem_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= dividend[DW-1] ^ divisor[31];
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sh - dsr_reg : rem_sh;
            q_reg   <= {q_reg[DW-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

@@ src/sor_linear_solver.sv @@
// SOR solver top: load path, sequencer, shared multiplier, stores, output register.
// Depends on sor_pkg and sor_div.
//
//  channel | dir | handshake            | contents
//  s_      | in  | s_tvalid / s_tready  | load element, tlast starts solve
//  m_      | out | m_tvalid / m_tready  | solution entry, tlast on last entry
//  cfg_    | in  | cfg_valid / cfg_ready| register index and data
//
// Load elements are taken one per cycle while the solver is idle. Each row update
// runs a read, multiply and accumulate step per matrix element, then the shared
// multiplier steps and the bit-serial divider; a sweep is n such updates plus a check.
// Results leave one entry at a time. Reset is synchronous, active low.
// m_ stalls hold the output register; the solver waits for it.
module sor_linear_solver #(
    parameter int SIZE = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[3:0], col[8:4], value[40:9], zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // index[3:0], solution[35:4], sweeps[51:36], pad
    output logic [1:0]  m_tuser,   // converged[0], pivot_fault[1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);
    localparam int MAX_N  = (SIZE < 16) ? SIZE : 16;
    localparam int EST_AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW     = $clog2(MAX_N + 1);
    localparam int CAW    = $clog2(SIZE * SIZE);

    sor_pkg::state_t state_reg, state_next;

    logic [17:0] relax_reg;
    logic [15:0] tol_reg, iter_reg;
    logic [4:0]  size_reg;

    logic [17:0]   w_cur;
    logic [15:0]   limit_cur;
    logic [CW-1:0] n_cur;

    logic [3:0]         in_row;
    logic [4:0]         in_col;
    logic signed [31:0] in_value;
    logic               in_acc;

    logic signed [31:0] coeff_mem [SIZE*SIZE];
    logic signed [31:0] rhs_mem [MAX_N];
    logic signed [31:0] est_mem [MAX_N];
    logic signed [31:0] coeff_q, rhs_q, est_q;
    logic               est_v_q;
    logic [MAX_N-1:0]   valid_reg;
    logic signed [31:0] xval;

    logic [CW-1:0]  i_reg, j_reg;
    logic [CW-1:0]  rd_idx;
    logic [CAW-1:0] wr_addr, rd_addr;
    logic [15:0]    sweep_reg;
    logic [31:0]    big_reg;
    logic           fault_reg, conv_reg;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] res_reg, diag_reg, old_reg;
    logic signed [32:0] part1_reg;

    logic                              div_start, div_done;
    logic signed [sor_pkg::DIV_W-1:0]  quo;

    logic signed [31:0] nv;
    logic signed [32:0] diff;
    logic [31:0]        dabs;
    logic               est_we, out_load, slot_free, row_last, i_last;

    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[8:4];
    assign in_value = s_tdata[40:9];
    assign in_acc   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relax_reg <= sor_pkg::W_ONE;
            tol_reg   <= 16'd7;
            iter_reg  <= 16'd1000;
            size_reg  <= 5'd11;
        end else if (cfg_valid) begin
            case (cfg_index)
                sor_pkg::REG_RELAX: relax_reg <= cfg_data;
                sor_pkg::REG_TOL:   tol_reg   <= cfg_data[15:0];
                sor_pkg::REG_ITER:  iter_reg  <= cfg_data[15:0];
                sor_pkg::REG_SIZE:  size_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign w_cur     = (relax_reg > sor_pkg::W_MAX) ? sor_pkg::W_MAX : relax_reg;
    assign limit_cur = (iter_reg == 16'd0) ? 16'd1 : iter_reg;
    always_comb begin
        if (size_reg < 5'd2) begin
            n_cur = CW'(2);
        end else if (size_reg > 5'(MAX_N)) begin
            n_cur = CW'(MAX_N);
        end else begin
            n_cur = CW'(size_reg);
        end
    end

    // storage
    assign wr_addr = CAW'(32'(in_row) * SIZE + 32'(in_col));
    assign rd_addr = CAW'(32'(i_reg) * SIZE + 32'(j_reg));
    assign rd_idx  = (state_reg == sor_pkg::ST_ORD || state_reg == sor_pkg::ST_OWR)
                     ? i_reg : j_reg;

    always_ff @(posedge aclk) begin
        if (in_acc && {1'b0, in_row} < 5'(n_cur) && in_col < 5'(n_cur)) begin
            coeff_mem[wr_addr] <= in_value;
        end
        coeff_q <= coeff_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_acc && {1'b0, in_row} < 5'(n_cur) && in_col == 5'(n_cur)) begin
            rhs_mem[EST_AW'(in_row)] <= in_value;
        end
        rhs_q <= rhs_mem[EST_AW'(i_reg)];
    end

    always_ff @(posedge aclk) begin
        if (est_we) begin
            est_mem[EST_AW'(i_reg)] <= nv;
        end
        est_q   <= est_mem[EST_AW'(rd_idx)];
        est_v_q <= valid_reg[EST_AW'(rd_idx)];
    end

    assign xval = est_v_q ? est_q : 32'sd0;

    // row update arithmetic
    assign nv   = (diag_reg == 32'sd0) ? old_reg
                  : sor_pkg::sat32(53'(part1_reg) + 53'(quo));
    assign diff = 33'(nv) - 33'(old_reg);
    assign dabs = diff[32] ? 32'(-diff) : diff[31:0];

    assign row_last  = (j_reg + 1'b1) == n_cur;
    assign i_last    = (i_reg + 1'b1) == n_cur;
    assign slot_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sor_pkg::ST_IDLE:  if (in_acc && s_tlast) state_next = sor_pkg::ST_RD;
            sor_pkg::ST_RD:    state_next = sor_pkg::ST_MUL;
            sor_pkg::ST_MUL:   state_next = sor_pkg::ST_ACC;
            sor_pkg::ST_ACC:   state_next = row_last ? sor_pkg::ST_RES : sor_pkg::ST_RD;
            sor_pkg::ST_RES:   state_next = sor_pkg::ST_M1;
            sor_pkg::ST_M1:    state_next = sor_pkg::ST_M2;
            sor_pkg::ST_M2:    state_next = sor_pkg::ST_DIV;
            sor_pkg::ST_DIV:   state_next = (diag_reg == 32'sd0) ? sor_pkg::ST_UPD
                                                                 : sor_pkg::ST_WAIT;
            sor_pkg::ST_WAIT:  if (div_done) state_next = sor_pkg::ST_UPD;
            sor_pkg::ST_UPD:   state_next = i_last ? sor_pkg::ST_SWEEP : sor_pkg::ST_RD;
            sor_pkg::ST_SWEEP: begin
                if (big_reg < {16'd0, tol_reg} || sweep_reg + 1'b1 == limit_cur) begin
                    state_next = sor_pkg::ST_ORD;
                end else begin
                    state_next = sor_pkg::ST_RD;
                end
            end
            sor_pkg::ST_ORD:   state_next = sor_pkg::ST_OWR;
            sor_pkg::ST_OWR:   if (slot_free) begin
                state_next = i_last ? sor_pkg::ST_IDLE : sor_pkg::ST_ORD;
            end
            default:           state_next = sor_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = state_reg == sor_pkg::ST_IDLE;
        div_start = state_reg == sor_pkg::ST_DIV && diag_reg != 32'sd0;
        est_we    = state_reg == sor_pkg::ST_UPD;
        out_load  = state_reg == sor_pkg::ST_OWR && slot_free;
        case (state_reg)
            sor_pkg::ST_M1: begin
                mul_a = $signed({15'd0, sor_pkg::W_ONE}) - $signed({15'd0, w_cur});
                mul_b = old_reg;
            end
            sor_pkg::ST_M2: begin
                mul_a = $signed({15'd0, w_cur});
                mul_b = res_reg;
            end
            default: begin
                mul_a = 33'(coeff_q);
                mul_b = xval;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sor_pkg::ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            sweep_reg   <= '0;
            big_reg     <= '0;
            fault_reg   <= 1'b0;
            conv_reg    <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                sor_pkg::ST_IDLE: if (in_acc && s_tlast) begin
                    i_reg     <= '0;
                    j_reg     <= '0;
                    sweep_reg <= '0;
                    big_reg   <= '0;
                    fault_reg <= 1'b0;
                    conv_reg  <= 1'b0;
                    valid_reg <= '0;
                end
                sor_pkg::ST_ACC:  j_reg <= row_last ? '0 : j_reg + 1'b1;
                sor_pkg::ST_DIV:  if (diag_reg == 32'sd0) fault_reg <= 1'b1;
                sor_pkg::ST_UPD: begin
                    valid_reg[EST_AW'(i_reg)] <= 1'b1;
                    if (dabs > big_reg) big_reg <= dabs;
                    i_reg <= i_last ? '0 : i_reg + 1'b1;
                end
                sor_pkg::ST_SWEEP: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (big_reg < {16'd0, tol_reg}) begin
                        conv_reg <= 1'b1;
                    end else if (sweep_reg + 1'b1 != limit_cur) begin
                        big_reg <= '0;
                    end
                end
                sor_pkg::ST_OWR:  if (slot_free) i_reg <= i_last ? '0 : i_reg + 1'b1;
                default: ;
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            sor_pkg::ST_RD: if (j_reg == '0) acc_reg <= '0;
            sor_pkg::ST_MUL: begin
                prod_reg <= mul_a * mul_b;
                if (j_reg == i_reg) begin
                    diag_reg <= coeff_q;
                    old_reg  <= xval;
                end
            end
            sor_pkg::ST_ACC: if (j_reg != i_reg) begin
                acc_reg <= acc_reg + 52'($signed(prod_reg[64:16]));
            end
            sor_pkg::ST_RES: res_reg <= sor_pkg::sat32(53'(rhs_q) - 53'(acc_reg));
            sor_pkg::ST_M1:  prod_reg <= mul_a * mul_b;
            sor_pkg::ST_M2: begin
                part1_reg <= prod_reg[48:16];
                prod_reg  <= mul_a * mul_b;
            end
            default: ;
        endcase
        if (out_load) begin
            m_data_reg <= {4'd0, sweep_reg, xval, 4'(i_reg)};
            m_user_reg <= {fault_reg, conv_reg};
            m_last_reg <= i_last;
        end
    end

    sor_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg[sor_pkg::DIV_W-1:0]),
        .divisor  (diag_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> diag_reg != 32'sd0)
        else $error("divider started on zero pivot");
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sor_pkg::ST_MUL |-> j_reg < n_cur && i_reg < n_cur)
        else $error("row or column index out of range");
    a_sweep_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sor_pkg::ST_SWEEP |-> sweep_reg < limit_cur)
        else $error("sweep count passed the limit");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == sor_pkg::ST_WAIT)
        else $error("divider result outside wait state");
`endif

endmodule
